[rtl/vdma_pkg.sv]
// ----------------------------------------------------------------------------
// vdma_pkg
// Shared types and constants for the VRAM DMA register block.
// ----------------------------------------------------------------------------
package vdma_pkg;

  // item action codes
  typedef enum logic [1:0] {
    ACT_REG_WRITE  = 2'd0,
    ACT_STAT_READ  = 2'd1,
    ACT_HBLANK     = 2'd2,
    ACT_LCD_OFF    = 2'd3
  } action_t;

  // register select codes
  localparam logic [2:0] SEL_SRC_HI = 3'd0;
  localparam logic [2:0] SEL_SRC_LO = 3'd1;
  localparam logic [2:0] SEL_DST_HI = 3'd2;
  localparam logic [2:0] SEL_DST_LO = 3'd3;
  localparam logic [2:0] SEL_CTRL   = 3'd4;

  localparam logic [7:0]  STATUS_IDLE = 8'hFF;
  localparam logic [7:0]  READ_IDLE   = 8'hFF;
  localparam logic [15:0] BLOCK_BYTES = 16'h0010;

  // one input item
  typedef struct packed {
    action_t    action;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic       lcd_enabled;
    logic       in_hblank;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0]  read_data;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [12:0] copy_dest;
    logic [7:0]  copy_blocks;
    logic        transfer_active;
  } result_t;

endpackage

[rtl/vdma_core.sv]
// ----------------------------------------------------------------------------
// vdma_core
// DMA register file and transfer state, with the single-pass update logic
// that turns one item into one result.
// ----------------------------------------------------------------------------
module vdma_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              color_mode,
  input  vdma_pkg::item_t   item,
  output vdma_pkg::result_t result
);
  import vdma_pkg::*;

  logic [7:0]  src_hi_r, src_hi_nxt;
  logic [7:0]  src_lo_r, src_lo_nxt;
  logic [7:0]  dst_hi_r, dst_hi_nxt;
  logic [7:0]  dst_lo_r, dst_lo_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [15:0] cur_src_r, cur_src_nxt;
  logic [15:0] cur_dst_r, cur_dst_nxt;
  logic [7:0]  blk_left_r, blk_left_nxt;
  logic        mode_r, mode_nxt;
  logic        latch_r, latch_nxt;

  logic [15:0] src_base, dst_base;
  logic [7:0]  ctrl_blocks;
  logic [15:0] blk_bytes;
  logic [15:0] end_src, end_dst;
  logic        arm_sel;
  logic [15:0] mb_src, mb_dst, mb_src_inc, mb_dst_inc;
  logic [7:0]  mb_bl, mb_bl_dec, mb_bl_dec2;
  logic        do_move;

  // address bases from the registers, block count from the written control value
  assign src_base    = {src_hi_r, src_lo_r[7:4], 4'b0000};
  assign dst_base    = {3'b000, dst_hi_r[4:0], dst_lo_r[7:4], 4'b0000};
  assign ctrl_blocks = {1'b0, item.write_data[6:0]} + 8'd1;
  assign blk_bytes   = {4'b0000, ctrl_blocks, 4'b0000};
  assign end_src     = src_base + blk_bytes;
  assign end_dst     = dst_base + blk_bytes;

  // block move operands: fresh ones when arming, else the running transfer
  assign mb_src     = arm_sel ? src_base : cur_src_r;
  assign mb_dst     = arm_sel ? dst_base : cur_dst_r;
  assign mb_bl      = arm_sel ? ctrl_blocks : blk_left_r;
  assign mb_src_inc = mb_src + BLOCK_BYTES;
  assign mb_dst_inc = mb_dst + BLOCK_BYTES;
  assign mb_bl_dec  = mb_bl - 8'd1;
  assign mb_bl_dec2 = mb_bl - 8'd2;

  // next state and result
  always_comb begin
    src_hi_nxt   = src_hi_r;
    src_lo_nxt   = src_lo_r;
    dst_hi_nxt   = dst_hi_r;
    dst_lo_nxt   = dst_lo_r;
    status_nxt   = status_r;
    cur_src_nxt  = cur_src_r;
    cur_dst_nxt  = cur_dst_r;
    blk_left_nxt = blk_left_r;
    mode_nxt     = mode_r;
    latch_nxt    = latch_r;
    arm_sel      = 1'b0;
    do_move      = 1'b0;
    result       = '0;
    result.read_data = READ_IDLE;

    case (item.action)
      ACT_REG_WRITE: begin
        if (color_mode) begin
          case (item.reg_select)
            SEL_SRC_HI: src_hi_nxt = item.write_data;
            SEL_SRC_LO: src_lo_nxt = item.write_data;
            SEL_DST_HI: dst_hi_nxt = item.write_data;
            SEL_DST_LO: dst_lo_nxt = item.write_data;
            SEL_CTRL: begin
              if (item.write_data[7]) begin
                // arm hblank transfer, maybe move the first block now
                arm_sel      = 1'b1;
                cur_src_nxt  = src_base;
                cur_dst_nxt  = dst_base;
                blk_left_nxt = ctrl_blocks;
                mode_nxt     = 1'b1;
                status_nxt   = {1'b0, item.write_data[6:0]};
                if (!item.lcd_enabled) begin
                  do_move = 1'b1;
                end else if (item.in_hblank && !latch_r) begin
                  do_move   = 1'b1;
                  latch_nxt = 1'b1;
                end
              end else if (mode_r) begin
                // pause the armed transfer
                mode_nxt     = 1'b0;
                blk_left_nxt = ctrl_blocks;
                status_nxt   = {1'b1, item.write_data[6:0]};
              end else begin
                // general copy of all blocks
                result.copy_valid  = 1'b1;
                result.copy_source = src_base;
                result.copy_dest   = dst_base[12:0];
                result.copy_blocks = ctrl_blocks;
                src_hi_nxt = end_src[15:8];
                src_lo_nxt = {end_src[7:4], 4'b0000};
                dst_hi_nxt = end_dst[15:8];
                dst_lo_nxt = {end_dst[7:4], 4'b0000};
                status_nxt = STATUS_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_STAT_READ: begin
        result.read_data = color_mode ? status_r : READ_IDLE;
      end
      ACT_HBLANK: begin
        latch_nxt = 1'b0;
        if (mode_r) begin
          do_move   = 1'b1;
          latch_nxt = 1'b1;
        end
      end
      ACT_LCD_OFF: begin
        if (mode_r) do_move = 1'b1;
      end
      default: ;
    endcase

    // one 16-byte block
    if (do_move) begin
      result.copy_valid  = 1'b1;
      result.copy_source = mb_src;
      result.copy_dest   = mb_dst[12:0];
      result.copy_blocks = 8'd1;
      cur_src_nxt  = mb_src_inc;
      cur_dst_nxt  = mb_dst_inc;
      src_hi_nxt   = mb_src_inc[15:8];
      src_lo_nxt   = {mb_src_inc[7:4], 4'b0000};
      dst_hi_nxt   = mb_dst_inc[15:8];
      dst_lo_nxt   = {mb_dst_inc[7:4], 4'b0000};
      blk_left_nxt = mb_bl_dec;
      if (mb_bl_dec == 8'd0) begin
        mode_nxt   = 1'b0;
        status_nxt = STATUS_IDLE;
      end else begin
        status_nxt = {1'b0, mb_bl_dec2[6:0]};
      end
    end

    result.transfer_active = mode_nxt;
  end

  // state registers, updated once per item, when fire is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_hi_r   <= '0;
      src_lo_r   <= '0;
      dst_hi_r   <= '0;
      dst_lo_r   <= '0;
      status_r   <= STATUS_IDLE;
      cur_src_r  <= '0;
      cur_dst_r  <= '0;
      blk_left_r <= '0;
      mode_r     <= 1'b0;
      latch_r    <= 1'b0;
    end else if (fire) begin
      src_hi_r   <= src_hi_nxt;
      src_lo_r   <= src_lo_nxt;
      dst_hi_r   <= dst_hi_nxt;
      dst_lo_r   <= dst_lo_nxt;
      status_r   <= status_nxt;
      cur_src_r  <= cur_src_nxt;
      cur_dst_r  <= cur_dst_nxt;
      blk_left_r <= blk_left_nxt;
      mode_r     <= mode_nxt;
      latch_r    <= latch_nxt;
    end
  end

endmodule

[rtl/vram_dma_controller.sv]
// ----------------------------------------------------------------------------
// vram_dma_controller
// VRAM DMA register block: register writes, status reads and video events
// in, one result per item out, with copy commands for the copy engine.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid/in_ready   | action, reg_select, write_data,
//           |           |                     | lcd_enabled, in_hblank
//  out_     | output    | out_valid/out_ready | read_data, copy_*, transfer_active
//  cfg_     | input     | cfg_we              | color_mode
//
// One item per cycle sustained while out_ready stays high; an item taken on in_
// passes the input register, then the result register with the state update,
// before out_valid rises for it.
// Reset (rst_n low, synchronous) empties both registers and restores the
// DMA registers; color_mode returns to 1.
// A stalled out_ already holding a result lets one more item into the input
// register; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module vram_dma_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_reg_select,
  input  logic [7:0]  in_write_data,
  input  logic        in_lcd_enabled,
  input  logic        in_in_hblank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_copy_valid,
  output logic [15:0] out_copy_source,
  output logic [12:0] out_copy_dest,
  output logic [7:0]  out_copy_blocks,
  output logic        out_transfer_active,
  input  logic        cfg_we,
  input  logic        cfg_color_mode
);
  import vdma_pkg::*;

  logic    color_mode_r;
  logic    s1_vld_r;
  item_t   s1_item_r;
  logic    s1_go;
  logic    out_vld_r;
  result_t out_res_r;
  result_t core_res;

  assign s1_go    = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_go;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b1;
    end else if (cfg_we) begin
      color_mode_r <= cfg_color_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.action      <= action_t'(in_action);
      s1_item_r.reg_select  <= in_reg_select;
      s1_item_r.write_data  <= in_write_data;
      s1_item_r.lcd_enabled <= in_lcd_enabled;
      s1_item_r.in_hblank   <= in_in_hblank;
    end
  end

  // register block and update logic
  vdma_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_go),
    .color_mode (color_mode_r),
    .item       (s1_item_r),
    .result     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) out_res_r <= core_res;
  end

  assign out_valid           = out_vld_r;
  assign out_read_data       = out_res_r.read_data;
  assign out_copy_valid      = out_res_r.copy_valid;
  assign out_copy_source     = out_res_r.copy_source;
  assign out_copy_dest       = out_res_r.copy_dest;
  assign out_copy_blocks     = out_res_r.copy_blocks;
  assign out_transfer_active = out_res_r.transfer_active;

endmodule
